FILE: hw/rtl/ttg_pkg.sv
// shared types and constants of the triangle tangent generator
`timescale 1ns / 1ps
package ttg_pkg;

    localparam int INDEX_BITS = 24;
    localparam int POS_BITS   = 32;
    localparam int DIFF_BITS  = POS_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int TAN_BITS   = PROD_BITS + 1;
    localparam int MAG_BITS   = PROD_BITS;
    localparam int NORM_BITS  = 30;
    localparam int SQ_BITS    = 2 * NORM_BITS + 2;
    localparam int ROOT_BITS  = NORM_BITS + 1;
    localparam int Q_BITS     = 15;
    localparam int OUT_SHIFT  = 14;
    localparam int NUM_BITS   = NORM_BITS + OUT_SHIFT + 1;
    localparam int OUT_BITS   = 16;
    localparam int ROOT_STEPS = SQ_BITS / 2;
    localparam int PADDR_BITS = 3;

    localparam logic [3:0] STEP_LAST_PROD = 4'd7;
    localparam logic [3:0] STEP_SQ_FIRST  = 4'd8;
    localparam logic [3:0] STEP_SQ_LAST   = 4'd10;

    localparam logic REG_INDEX_BASE = 1'b0;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL,
        OP_MAG,
        OP_NORM,
        OP_ROOT_INIT,
        OP_ROOT,
        OP_DIV_INIT,
        OP_DIV,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] step;
        logic       capture;
        logic [1:0] slot;
    } cmd_t;

    typedef struct packed {
        logic degen;
        logic norm_done;
        logic out_busy;
    } status_t;

endpackage

FILE: hw/rtl/ttg_datapath.sv
// datapath: vertex hold, shared multiplier, normalize, square root, divider, output register
`timescale 1ns / 1ps
module ttg_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  ttg_pkg::cmd_t                         cmd,
    output ttg_pkg::status_t                      status,
    input  logic [ttg_pkg::INDEX_BITS-1:0]        index_base,
    input  logic [ttg_pkg::INDEX_BITS-1:0]        s_vertex_index,
    input  logic signed [ttg_pkg::POS_BITS-1:0]   s_pos_x,
    input  logic signed [ttg_pkg::POS_BITS-1:0]   s_pos_y,
    input  logic signed [ttg_pkg::POS_BITS-1:0]   s_pos_z,
    input  logic signed [ttg_pkg::POS_BITS-1:0]   s_tex_u,
    input  logic signed [ttg_pkg::POS_BITS-1:0]   s_tex_v,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ttg_pkg::OUT_BITS-1:0]   m_tangent_x,
    output logic signed [ttg_pkg::OUT_BITS-1:0]   m_tangent_y,
    output logic signed [ttg_pkg::OUT_BITS-1:0]   m_tangent_z,
    output logic                                  m_degenerate,
    output logic [ttg_pkg::INDEX_BITS-1:0]        m_corner_a,
    output logic [ttg_pkg::INDEX_BITS-1:0]        m_corner_b,
    output logic [ttg_pkg::INDEX_BITS-1:0]        m_corner_c
);

    localparam int DW = ttg_pkg::DIFF_BITS;
    localparam int PW = ttg_pkg::PROD_BITS;
    localparam int TW = ttg_pkg::TAN_BITS;
    localparam int MW = ttg_pkg::MAG_BITS;
    localparam int NB = ttg_pkg::NORM_BITS;
    localparam int SW = ttg_pkg::SQ_BITS;
    localparam int RW = ttg_pkg::ROOT_BITS;
    localparam int QW = ttg_pkg::Q_BITS;
    localparam int NW = ttg_pkg::NUM_BITS;
    localparam int IW = ttg_pkg::INDEX_BITS;
    localparam int XW = ttg_pkg::POS_BITS;
    localparam int OW = ttg_pkg::OUT_BITS;

    // held corners
    logic [IW-1:0]        idx_reg [3];
    logic signed [XW-1:0] pos_reg [2][3];
    logic signed [XW-1:0] tex_reg [2][2];

    // edges and uv deltas
    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic signed [DW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic signed [PW-1:0] prod_reg;
    logic                 acc_valid_reg;
    logic [3:0]           acc_step_reg;
    logic signed [TW-1:0] det_reg;
    logic signed [TW-1:0] tc_reg [3];
    logic [MW-1:0]        mag_reg [3];
    logic                 neg_reg [3];
    logic                 degen_reg;
    logic [SW-1:0]        sq_reg;

    logic [SW-1:0]        rv_reg, res_reg, bit_reg;
    logic [RW-1:0]        rem_reg;
    logic [QW-1:0]        low_reg;
    logic [QW-1:0]        q_reg [3];

    logic                 out_valid_reg;
    logic signed [OW-1:0] tan_reg [3];
    logic                 out_degen_reg;
    logic [IW-1:0]        corner_reg [3];

    logic [IW-1:0]        rebased;
    logic signed [DW-1:0] mul_a, mul_b;
    logic [MW-1:0]        mag_or;
    logic                 big, big8;
    logic [SW-1:0]        trial;
    logic [RW-1:0]        n_eff;
    logic [NW-1:0]        num;
    logic [RW:0]          dtrial;
    logic [1:0]           dk;

    assign rebased = s_vertex_index - index_base;
    assign dk      = cmd.step[1:0];

    function automatic logic signed [DW-1:0] sdiff(input logic signed [XW-1:0] a,
                                                   input logic signed [XW-1:0] b);
        sdiff = DW'(a) - DW'(b);
    endfunction

    function automatic logic signed [DW-1:0] magop(input logic [MW-1:0] m);
        magop = DW'(m[NB-1:0]);
    endfunction

    // multiplier operand select
    always_comb begin
        mul_a = du1_reg;
        mul_b = dv2_reg;
        unique case (cmd.step)
            4'd0:    begin mul_a = du1_reg; mul_b = dv2_reg;   end
            4'd1:    begin mul_a = du2_reg; mul_b = dv1_reg;   end
            4'd2:    begin mul_a = dv2_reg; mul_b = e1_reg[0]; end
            4'd3:    begin mul_a = dv1_reg; mul_b = e2_reg[0]; end
            4'd4:    begin mul_a = dv2_reg; mul_b = e1_reg[1]; end
            4'd5:    begin mul_a = dv1_reg; mul_b = e2_reg[1]; end
            4'd6:    begin mul_a = dv2_reg; mul_b = e1_reg[2]; end
            4'd7:    begin mul_a = dv1_reg; mul_b = e2_reg[2]; end
            4'd8:    begin mul_a = magop(mag_reg[0]); mul_b = magop(mag_reg[0]); end
            4'd9:    begin mul_a = magop(mag_reg[1]); mul_b = magop(mag_reg[1]); end
            4'd10:   begin mul_a = magop(mag_reg[2]); mul_b = magop(mag_reg[2]); end
            default: begin mul_a = du1_reg; mul_b = dv2_reg;   end
        endcase
    end

    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign big    = |mag_or[MW-1:NB];
    assign big8   = |mag_or[MW-1:NB+8];

    assign trial  = res_reg + bit_reg;
    assign n_eff  = (res_reg[RW-1:0] == '0) ? RW'(1) : res_reg[RW-1:0];
    assign num    = {1'b0, mag_reg[dk][NB-1:0], {ttg_pkg::OUT_SHIFT{1'b0}}}
                    + NW'(n_eff >> 1);
    assign dtrial = {rem_reg, low_reg[QW-1]};

    always_ff @(posedge aclk) begin
        // vertex capture
        if (cmd.capture) begin
            idx_reg[cmd.slot] <= rebased;
            if (cmd.slot != 2'd2) begin
                pos_reg[cmd.slot[0]][0] <= s_pos_x;
                pos_reg[cmd.slot[0]][1] <= s_pos_y;
                pos_reg[cmd.slot[0]][2] <= s_pos_z;
                tex_reg[cmd.slot[0]][0] <= s_tex_u;
                tex_reg[cmd.slot[0]][1] <= s_tex_v;
            end else begin
                e1_reg[0] <= sdiff(pos_reg[1][0], pos_reg[0][0]);
                e1_reg[1] <= sdiff(pos_reg[1][1], pos_reg[0][1]);
                e1_reg[2] <= sdiff(pos_reg[1][2], pos_reg[0][2]);
                e2_reg[0] <= sdiff(s_pos_x, pos_reg[0][0]);
                e2_reg[1] <= sdiff(s_pos_y, pos_reg[0][1]);
                e2_reg[2] <= sdiff(s_pos_z, pos_reg[0][2]);
                du1_reg   <= sdiff(tex_reg[1][0], tex_reg[0][0]);
                dv1_reg   <= sdiff(tex_reg[1][1], tex_reg[0][1]);
                du2_reg   <= sdiff(s_tex_u, tex_reg[0][0]);
                dv2_reg   <= sdiff(s_tex_v, tex_reg[0][1]);
            end
        end

        // product is registered, then accumulated in the following cycle
        prod_reg     <= PW'(mul_a) * PW'(mul_b);
        acc_step_reg <= cmd.step;
        if (acc_valid_reg) begin
            unique case (acc_step_reg)
                4'd0:    det_reg   <= TW'(prod_reg);
                4'd1:    det_reg   <= det_reg - TW'(prod_reg);
                4'd2:    tc_reg[0] <= TW'(prod_reg);
                4'd3:    tc_reg[0] <= tc_reg[0] - TW'(prod_reg);
                4'd4:    tc_reg[1] <= TW'(prod_reg);
                4'd5:    tc_reg[1] <= tc_reg[1] - TW'(prod_reg);
                4'd6:    tc_reg[2] <= TW'(prod_reg);
                4'd7:    tc_reg[2] <= tc_reg[2] - TW'(prod_reg);
                4'd8:    sq_reg    <= prod_reg[SW-1:0];
                default: sq_reg    <= sq_reg + prod_reg[SW-1:0];
            endcase
        end

        unique case (cmd.op)
            ttg_pkg::OP_MAG: begin
                for (int k = 0; k < 3; k++) begin
                    mag_reg[k] <= tc_reg[k][TW-1] ? MW'(-tc_reg[k]) : MW'(tc_reg[k]);
                    neg_reg[k] <= tc_reg[k][TW-1] ^ det_reg[TW-1];
                end
                degen_reg <= (det_reg == '0)
                             || ((tc_reg[0] == '0) && (tc_reg[1] == '0) && (tc_reg[2] == '0));
            end
            ttg_pkg::OP_NORM: begin
                // truncating shifts compose, so coarse steps then single steps
                for (int k = 0; k < 3; k++) begin
                    if (big8) begin
                        mag_reg[k] <= mag_reg[k] >> 8;
                    end else if (big) begin
                        mag_reg[k] <= mag_reg[k] >> 1;
                    end
                end
            end
            ttg_pkg::OP_ROOT_INIT: begin
                rv_reg  <= sq_reg;
                res_reg <= '0;
                bit_reg <= SW'(1) << (SW - 2);
            end
            ttg_pkg::OP_ROOT: begin
                if (rv_reg >= trial) begin
                    rv_reg  <= rv_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ttg_pkg::OP_DIV_INIT: begin
                rem_reg    <= RW'(num[NW-1:QW]);
                low_reg    <= num[QW-1:0];
                q_reg[dk]  <= '0;
            end
            ttg_pkg::OP_DIV: begin
                if (dtrial >= (RW+1)'(n_eff)) begin
                    rem_reg   <= RW'(dtrial - (RW+1)'(n_eff));
                    q_reg[dk] <= {q_reg[dk][QW-2:0], 1'b1};
                end else begin
                    rem_reg   <= dtrial[RW-1:0];
                    q_reg[dk] <= {q_reg[dk][QW-2:0], 1'b0};
                end
                low_reg <= low_reg << 1;
            end
            default: ;
        endcase

        if (cmd.op == ttg_pkg::OP_OUT) begin
            for (int k = 0; k < 3; k++) begin
                if (degen_reg) begin
                    tan_reg[k] <= '0;
                end else if (neg_reg[k]) begin
                    tan_reg[k] <= -OW'(q_reg[k]);
                end else begin
                    tan_reg[k] <= OW'(q_reg[k]);
                end
                corner_reg[k] <= idx_reg[k];
            end
            out_degen_reg <= degen_reg;
        end

        if (!aresetn) begin
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_valid_reg <= (cmd.op == ttg_pkg::OP_MUL);
            if (cmd.op == ttg_pkg::OP_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.degen     = degen_reg;
    assign status.norm_done = !big;
    assign status.out_busy  = out_valid_reg && !m_ready;

    assign m_valid      = out_valid_reg;
    assign m_tangent_x  = tan_reg[0];
    assign m_tangent_y  = tan_reg[1];
    assign m_tangent_z  = tan_reg[2];
    assign m_degenerate = out_degen_reg;
    assign m_corner_a   = corner_reg[0];
    assign m_corner_b   = corner_reg[1];
    assign m_corner_c   = corner_reg[2];

endmodule

FILE: hw/rtl/ttg_ctrl.sv
// controller: corner counting and sequencing of the tangent computation
`timescale 1ns / 1ps
module ttg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ttg_pkg::status_t  status,
    output ttg_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_FLUSH,
        S_MAG,
        S_CHECK,
        S_NORM,
        S_SQ,
        S_SQ_FLUSH,
        S_ROOT_INIT,
        S_ROOT,
        S_DIV_INIT,
        S_DIV,
        S_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] count_reg;
    logic [3:0] step_reg;
    logic [4:0] cnt_reg;
    logic       accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd.op      = ttg_pkg::OP_NONE;
        cmd.step    = step_reg;
        cmd.capture = accept;
        cmd.slot    = count_reg;
        unique case (state_reg)
            S_MUL, S_SQ: cmd.op = ttg_pkg::OP_MUL;
            S_MAG:       cmd.op = ttg_pkg::OP_MAG;
            S_NORM:      cmd.op = ttg_pkg::OP_NORM;
            S_ROOT_INIT: cmd.op = ttg_pkg::OP_ROOT_INIT;
            S_ROOT:      cmd.op = ttg_pkg::OP_ROOT;
            S_DIV_INIT:  cmd.op = ttg_pkg::OP_DIV_INIT;
            S_DIV:       cmd.op = ttg_pkg::OP_DIV;
            S_OUT:       cmd.op = status.out_busy ? ttg_pkg::OP_NONE : ttg_pkg::OP_OUT;
            default:     cmd.op = ttg_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (count_reg == 2'd2) begin
                            count_reg <= '0;
                            step_reg  <= '0;
                            state_reg <= S_MUL;
                        end else begin
                            count_reg <= count_reg + 2'd1;
                        end
                    end
                end
                S_MUL: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == ttg_pkg::STEP_LAST_PROD) begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH: state_reg <= S_MAG;
                S_MAG:   state_reg <= S_CHECK;
                S_CHECK: begin
                    state_reg <= status.degen ? S_OUT : S_NORM;
                end
                S_NORM: begin
                    if (status.norm_done) begin
                        step_reg  <= ttg_pkg::STEP_SQ_FIRST;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == ttg_pkg::STEP_SQ_LAST) begin
                        state_reg <= S_SQ_FLUSH;
                    end
                end
                S_SQ_FLUSH: state_reg <= S_ROOT_INIT;
                S_ROOT_INIT: begin
                    cnt_reg   <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(ttg_pkg::ROOT_STEPS - 1)) begin
                        step_reg  <= '0;
                        state_reg <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(ttg_pkg::Q_BITS - 1)) begin
                        if (step_reg == 4'd2) begin
                            state_reg <= S_OUT;
                        end else begin
                            step_reg  <= step_reg + 4'd1;
                            state_reg <= S_DIV_INIT;
                        end
                    end
                end
                S_OUT: begin
                    if (!status.out_busy) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_third_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && count_reg == 2'd2) |=> (state_reg == S_MUL && count_reg == 2'd0))
        else $error("third corner did not start computation");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("corner count out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ttg_pkg::OP_OUT) |-> !status.out_busy)
        else $error("result loaded over a pending transfer");

    a_count_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |=> $stable(count_reg) || state_reg == S_IDLE)
        else $error("corner count moved while busy");

endmodule

FILE: hw/rtl/triangle_tangent_generator.sv
// top level: configuration register, controller and datapath
// sequence after the third corner transfer: 8 products, normalize, 31-step square root,
// three divisions, output; a degenerate triangle goes from the check straight to the output
// throughput: one vertex per cycle for the first two corners, then the shared
// multiplier, the root and the divider hold the input until the triangle's result is loaded
// reset: synchronous active-low aresetn clears corner count, control and index_base
`timescale 1ns / 1ps
module triangle_tangent_generator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ttg_pkg::PADDR_BITS-1:0]        paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ttg_pkg::INDEX_BITS-1:0]        s_vertex_index,
    input  logic signed [ttg_pkg::POS_BITS-1:0]   s_pos_x,
    input  logic signed [ttg_pkg::POS_BITS-1:0]   s_pos_y,
    input  logic signed [ttg_pkg::POS_BITS-1:0]   s_pos_z,
    input  logic signed [ttg_pkg::POS_BITS-1:0]   s_tex_u,
    input  logic signed [ttg_pkg::POS_BITS-1:0]   s_tex_v,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ttg_pkg::OUT_BITS-1:0]   m_tangent_x,
    output logic signed [ttg_pkg::OUT_BITS-1:0]   m_tangent_y,
    output logic signed [ttg_pkg::OUT_BITS-1:0]   m_tangent_z,
    output logic                                  m_degenerate,
    output logic [ttg_pkg::INDEX_BITS-1:0]        m_corner_a,
    output logic [ttg_pkg::INDEX_BITS-1:0]        m_corner_b,
    output logic [ttg_pkg::INDEX_BITS-1:0]        m_corner_c
);

    logic [ttg_pkg::INDEX_BITS-1:0] index_base_reg;
    ttg_pkg::cmd_t    cmd;
    ttg_pkg::status_t status;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ttg_pkg::PADDR_BITS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_base_reg <= '0;
        end else if (psel && penable && pwrite && reg_sel == ttg_pkg::REG_INDEX_BASE) begin
            index_base_reg <= pwdata[ttg_pkg::INDEX_BITS-1:0];
        end
    end

    assign prdata = (reg_sel == ttg_pkg::REG_INDEX_BASE) ? 32'(index_base_reg) : '0;

    ttg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ttg_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .index_base     (index_base_reg),
        .s_vertex_index (s_vertex_index),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_tex_u        (s_tex_u),
        .s_tex_v        (s_tex_v),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tangent_x    (m_tangent_x),
        .m_tangent_y    (m_tangent_y),
        .m_tangent_z    (m_tangent_z),
        .m_degenerate   (m_degenerate),
        .m_corner_a     (m_corner_a),
        .m_corner_b     (m_corner_b),
        .m_corner_c     (m_corner_c)
    );

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for the triangle tangent generator
`timescale 1ns / 1ps
module tb_top;

    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 150;
    localparam int TRIS_PER_PH = 150;

    typedef struct {
        logic signed [ttg_pkg::OUT_BITS-1:0] tx, ty, tz;
        logic                                degen;
        logic [ttg_pkg::INDEX_BITS-1:0]      ca, cb, cc;
    } tangent_t;

    class tangent_scoreboard;
        logic [ttg_pkg::INDEX_BITS-1:0]      index_base;
        int                                  corners;
        logic [ttg_pkg::INDEX_BITS-1:0]      corner_idx [2];
        logic signed [ttg_pkg::POS_BITS-1:0] corner_pos [2][3];
        logic signed [ttg_pkg::POS_BITS-1:0] corner_tex [2][2];
        tangent_t                            expected_q [$];
        int                                  errors;
        int                                  checked;
        int                                  degen_seen;

        function new();
            index_base = '0;
            corners    = 0;
            errors     = 0;
            checked    = 0;
            degen_seen = 0;
        endfunction

        static function logic [63:0] isqrt(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // third corner completes the triangle and yields one tangent
        function void note_vertex(logic [ttg_pkg::INDEX_BITS-1:0] vidx,
                                  logic signed [ttg_pkg::POS_BITS-1:0] px, py, pz, tu, tv);
            logic [ttg_pkg::INDEX_BITS-1:0]      rebased;
            logic signed [127:0]                 e1 [3];
            logic signed [127:0]                 e2 [3];
            logic signed [127:0]                 du1, dv1, du2, dv2, det;
            logic signed [127:0]                 tc [3];
            logic [127:0]                        mag [3];
            logic [127:0]                        all_bits;
            logic [63:0]                         m [3];
            logic [63:0]                         sq, n, q;
            logic signed [ttg_pkg::POS_BITS-1:0] p2 [3];
            int                                  len, s;
            tangent_t                            r;
            rebased = vidx - index_base;
            if (corners < 2) begin
                corner_idx[corners]    = rebased;
                corner_pos[corners][0] = px;
                corner_pos[corners][1] = py;
                corner_pos[corners][2] = pz;
                corner_tex[corners][0] = tu;
                corner_tex[corners][1] = tv;
                corners++;
                return;
            end
            corners = 0;
            p2[0] = px; p2[1] = py; p2[2] = pz;
            for (int k = 0; k < 3; k++) begin
                e1[k] = 128'(corner_pos[1][k]) - 128'(corner_pos[0][k]);
                e2[k] = 128'(p2[k]) - 128'(corner_pos[0][k]);
            end
            du1 = 128'(corner_tex[1][0]) - 128'(corner_tex[0][0]);
            dv1 = 128'(corner_tex[1][1]) - 128'(corner_tex[0][1]);
            du2 = 128'(tu) - 128'(corner_tex[0][0]);
            dv2 = 128'(tv) - 128'(corner_tex[0][1]);
            det = du1 * dv2 - du2 * dv1;
            all_bits = '0;
            for (int k = 0; k < 3; k++) begin
                tc[k] = dv2 * e1[k] - dv1 * e2[k];
                mag[k] = tc[k] < 0 ? -tc[k] : tc[k];
                all_bits |= mag[k];
            end
            r.ca = corner_idx[0];
            r.cb = corner_idx[1];
            r.cc = rebased;
            r.degen = (det == 0) || (all_bits == 0);
            r.tx = '0; r.ty = '0; r.tz = '0;
            if (!r.degen) begin
                len = 0;
                for (int i = 0; i < 128; i++) if (all_bits[i]) len = i + 1;
                s = len > ttg_pkg::NORM_BITS ? len - ttg_pkg::NORM_BITS : 0;
                sq = 0;
                for (int k = 0; k < 3; k++) begin
                    m[k] = 64'(mag[k] >> s);
                    sq += m[k] * m[k];
                end
                n = isqrt(sq);
                if (n == 0) n = 1;
                for (int k = 0; k < 3; k++) begin
                    q = (m[k] * 64'd16384 + n / 2) / n;
                    if (q > 16384) q = 16384;
                    if ((tc[k] < 0) != (det < 0)) q = -q;
                    case (k)
                        0: r.tx = q[15:0];
                        1: r.ty = q[15:0];
                        default: r.tz = q[15:0];
                    endcase
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(tangent_t got);
            tangent_t e;
            if (expected_q.size() == 0) begin
                $error("tangent transfer with nothing expected");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.degen) degen_seen++;
            if (got.tx !== e.tx) begin
                $error("tangent_x exp %0d got %0d", e.tx, got.tx); errors++;
            end
            if (got.ty !== e.ty) begin
                $error("tangent_y exp %0d got %0d", e.ty, got.ty); errors++;
            end
            if (got.tz !== e.tz) begin
                $error("tangent_z exp %0d got %0d", e.tz, got.tz); errors++;
            end
            if (got.degen !== e.degen) begin
                $error("degenerate exp %0b got %0b", e.degen, got.degen); errors++;
            end
            if (got.ca !== e.ca) begin
                $error("corner_a exp %h got %h", e.ca, got.ca); errors++;
            end
            if (got.cb !== e.cb) begin
                $error("corner_b exp %h got %h", e.cb, got.cb); errors++;
            end
            if (got.cc !== e.cc) begin
                $error("corner_c exp %h got %h", e.cc, got.cc); errors++;
            end
        endfunction
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                psel, penable, pwrite, pready;
    logic [ttg_pkg::PADDR_BITS-1:0]      paddr;
    logic [31:0]                         pwdata, prdata;
    logic                                s_valid, s_ready;
    logic [ttg_pkg::INDEX_BITS-1:0]      s_vertex_index;
    logic signed [ttg_pkg::POS_BITS-1:0] s_pos_x, s_pos_y, s_pos_z, s_tex_u, s_tex_v;
    logic                                m_valid, m_ready;
    logic signed [ttg_pkg::OUT_BITS-1:0] m_tangent_x, m_tangent_y, m_tangent_z;
    logic                                m_degenerate;
    logic [ttg_pkg::INDEX_BITS-1:0]      m_corner_a, m_corner_b, m_corner_c;

    tangent_scoreboard tangents = new();
    int                idle_cycles;
    int                triangles_sent;

    triangle_tangent_generator DUT (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // result monitor samples at the edge, before any driver update lands
    always @(posedge aclk) begin
        tangent_t got;
        if (aresetn && m_valid && m_ready) begin
            got.tx = m_tangent_x; got.ty = m_tangent_y; got.tz = m_tangent_z;
            got.degen = m_degenerate;
            got.ca = m_corner_a; got.cb = m_corner_b; got.cc = m_corner_c;
            tangents.check_result(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stall, sometimes none, before each transfer
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    task automatic write_index_base(logic [ttg_pkg::INDEX_BITS-1:0] value);
        paddr   <= ttg_pkg::PADDR_BITS'({ttg_pkg::REG_INDEX_BASE, 2'b00});
        pwdata  <= 32'(value);
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        tangents.index_base = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // the sender goes quiet so the last vertex is not offered again
    task automatic drain();
        s_valid <= 1'b0;
        while (tangents.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic send_vertex(logic [ttg_pkg::INDEX_BITS-1:0] vidx,
                               logic signed [ttg_pkg::POS_BITS-1:0] px, py, pz, tu, tv,
                               bit dense);
        int gap;
        gap = dense ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_vertex_index <= vidx;
        s_pos_x <= px; s_pos_y <= py; s_pos_z <= pz;
        s_tex_u <= tu; s_tex_v <= tv;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        tangents.note_vertex(vidx, px, py, pz, tu, tv);
    endtask

    function automatic logic signed [ttg_pkg::POS_BITS-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2, 3:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            4:       return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0;
                    default: return -32'sh1;
                endcase
            end
        endcase
    endfunction

    // random triangle; some are built to collapse the uv or position span
    task automatic send_random_triangle(bit dense);
        logic signed [ttg_pkg::POS_BITS-1:0] p [3][3];
        logic signed [ttg_pkg::POS_BITS-1:0] t [3][2];
        int shape;
        shape = $urandom_range(0, 19);
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) p[c][k] = pick_coord();
            t[c][0] = pick_coord();
            t[c][1] = pick_coord();
        end
        if (shape == 0) begin
            t[2] = t[0];
        end else if (shape == 1) begin
            t[1][1] = t[0][1];
            t[2][1] = t[0][1];
        end else if (shape == 2) begin
            p[1] = p[0];
            p[2] = p[0];
        end else if (shape == 3) begin
            t[2][0] = t[1][0];
            t[2][1] = t[1][1];
        end
        for (int c = 0; c < 3; c++)
            send_vertex(ttg_pkg::INDEX_BITS'($urandom), p[c][0], p[c][1], p[c][2],
                        t[c][0], t[c][1], dense);
        triangles_sent++;
    endtask

    task automatic send_triangle(logic [ttg_pkg::INDEX_BITS-1:0] i0, i1, i2,
                                 logic signed [ttg_pkg::POS_BITS-1:0] ax, ay, az, au, av,
                                 logic signed [ttg_pkg::POS_BITS-1:0] bx, by, bz, bu, bv,
                                 logic signed [ttg_pkg::POS_BITS-1:0] cx, cy, cz, cu, cv);
        send_vertex(i0, ax, ay, az, au, av, 1'b0);
        send_vertex(i1, bx, by, bz, bu, bv, 1'b0);
        send_vertex(i2, cx, cy, cz, cu, cv, 1'b0);
        triangles_sent++;
    endtask

    initial begin
        logic signed [ttg_pkg::POS_BITS-1:0] big, low, one;
        big = 32'sh7fff_ffff;
        low = 32'sh8000_0000;
        one = 32'sh0001_0000;
        triangles_sent = 0;
        aresetn <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        s_valid <= 1'b0;
        s_vertex_index <= '0;
        s_pos_x <= '0; s_pos_y <= '0; s_pos_z <= '0; s_tex_u <= '0; s_tex_v <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_index_base('0);
        // plain unit triangle, positive determinant
        send_triangle(0, 1, 2, 0, 0, 0, 0, 0, one, 0, 0, one, 0, 0, one, 0, 0, one);
        // mirrored uv gives negative determinant
        send_triangle(3, 4, 5, 0, 0, 0, 0, 0, one, 0, 0, -one, 0, 0, one, 0, 0, one);
        // coincident uvs: zero determinant
        send_triangle(6, 7, 8, 0, 0, 0, 5, 5, one, one, 0, 5, 5, 0, one, one, 5, 5);
        // all corners at one position: zero tangent with nonzero determinant
        send_triangle(9, 10, 11, one, one, one, 0, 0, one, one, one, one, 0,
                      one, one, one, 0, one);
        // position and uv extremes in opposite corners
        send_triangle(24'hffffff, 24'h0, 24'h800000, low, low, low, low, low,
                      big, big, big, big, low, low, big, big, low, big);
        send_triangle(24'h7fffff, 24'hffffff, 24'h1, big, low, big, low, big,
                      low, big, low, big, big, big, big, low, low, low);
        drain();

        // index rebasing with wrap below zero
        write_index_base(24'hffffff);
        send_triangle(24'h0, 24'hffffff, 24'h123456, 0, 0, 0, 0, 0,
                      one, 3, -7, one, 9, 2, one, 0, -one, one);
        for (int i = 0; i < TRIS_PER_PH; i++) send_random_triangle($urandom_range(0, 4) == 0);
        drain();

        write_index_base(ttg_pkg::INDEX_BITS'($urandom));
        for (int i = 0; i < TRIS_PER_PH; i++) begin
            send_random_triangle($urandom_range(0, 4) == 0);
            if (i == TRIS_PER_PH / 2) begin
                s_valid <= 1'b0;
                while (tangents.expected_q.size() != 0) @(posedge aclk);
            end
        end
        drain();

        write_index_base(24'h000001);
        for (int i = 0; i < TRIS_PER_PH; i++) send_random_triangle(i < 40);
        drain();

        write_index_base('0);
        for (int i = 0; i < TRIS_PER_PH; i++) send_random_triangle($urandom_range(0, 4) == 0);
        drain();

        $display("covered %0d triangles over 5 index_base settings, %0d tangents checked",
                 triangles_sent, tangents.checked);
        $display("degenerate results seen: %0d, check errors: %0d",
                 tangents.degen_seen, tangents.errors);
        if (tangents.errors == 0 && tangents.expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
